[hdl/signed_integer_to_radix_digits_assert.svh]
// Assertion macros used by the checker file of this block.
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

// Clocked assertion that is switched off while reset is applied.
`define SIRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define SIRD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/sird_pkg.sv]
`timescale 1ns / 1ps

package sird_pkg;

  // Field and register widths.
  localparam int VAL_W      = 32;
  localparam int SYM_W      = 8;
  localparam int STAT_W     = 3;
  localparam int LEN_W      = 5;
  localparam int DIG_W      = 4;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int ALPHA_W    = 128;
  localparam int BIT_CNT_W  = $clog2(VAL_W);

  // Alphabet capacity and the cap on the radix.
  localparam int SYMBOL_SLOTS = 16;
  localparam int MAX_BASE     = 16;
  localparam int LEN_CAP      = (MAX_BASE < SYMBOL_SLOTS) ? MAX_BASE : SYMBOL_SLOTS;

  // Digit stack depth: base 2 needs one digit per magnitude bit.
  localparam int DIG_MAX = VAL_W;
  localparam int ND_W    = $clog2(DIG_MAX + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HI = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_SHORT = 3'd1;
  localparam logic [STAT_W-1:0] ST_SPACE = 3'd2;
  localparam logic [STAT_W-1:0] ST_SIGN  = 3'd3;
  localparam logic [STAT_W-1:0] ST_DUP   = 3'd4;

  // Characters of interest.
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] CH_CR    = 8'h0D;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

  // Result of the alphabet scan.
  typedef struct packed {
    logic              done;
    logic [STAT_W-1:0] status;
  } chk_res_t;

  // Result of one division by the radix.
  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
    logic [DIG_W-1:0] digit;
  } div_res_t;

  // Symbol idx of the packed alphabet.
  function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_W-1:0] alpha,
                                              input logic [DIG_W-1:0] idx);
    sym_at = alpha[idx*SYM_W +: SYM_W];
  endfunction

endpackage

[hdl/sird_alpha_chk.sv]
`timescale 1ns / 1ps

module sird_alpha_chk (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic [sird_pkg::LEN_W-1:0]        len,
  input  logic [sird_pkg::ALPHA_W-1:0]      alpha,
  output sird_pkg::chk_res_t                res
);

  logic                             run_r;
  logic                             done_r;
  logic [sird_pkg::STAT_W-1:0]      status_r;
  logic [sird_pkg::DIG_W-1:0]       idx_r;

  logic                             zero_any;
  logic                             dup;
  logic                             blank;
  logic                             sign;
  logic                             at_end;
  logic [sird_pkg::SYM_W-1:0]       cur;

  // Compare the symbol under scan with every later symbol in use; test all in use for zero.
  always_comb begin
    cur      = sird_pkg::sym_at(alpha, idx_r);
    zero_any = 1'b0;
    dup      = 1'b0;
    for (int k = 0; k < sird_pkg::SYMBOL_SLOTS; k++) begin
      if (sird_pkg::LEN_W'(k) < len) begin
        if (sird_pkg::sym_at(alpha, sird_pkg::DIG_W'(k)) == '0) begin
          zero_any = 1'b1;
        end
        if ((sird_pkg::LEN_W'(k) > {1'b0, idx_r}) &&
            (sird_pkg::sym_at(alpha, sird_pkg::DIG_W'(k)) == cur)) begin
          dup = 1'b1;
        end
      end
    end
    blank  = cur inside {sird_pkg::CH_SPACE, [sird_pkg::CH_TAB:sird_pkg::CH_CR]};
    sign   = cur inside {sird_pkg::CH_PLUS, sird_pkg::CH_MINUS};
    at_end = ({1'b0, idx_r} == (len - sird_pkg::LEN_W'(1)));
  end

  // Length and zero test at once, then one symbol per cycle from index 0 up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      done_r   <= 1'b0;
      status_r <= sird_pkg::ST_OK;
      idx_r    <= '0;
    end else begin
      if (go) begin
        idx_r <= '0;
        if ((len < sird_pkg::LEN_W'(2)) || zero_any) begin
          done_r   <= 1'b1;
          status_r <= sird_pkg::ST_SHORT;
        end else begin
          done_r <= 1'b0;
          run_r  <= 1'b1;
        end
      end else if (run_r) begin
        if (blank) begin
          run_r    <= 1'b0;
          done_r   <= 1'b1;
          status_r <= sird_pkg::ST_SPACE;
        end else if (sign) begin
          run_r    <= 1'b0;
          done_r   <= 1'b1;
          status_r <= sird_pkg::ST_SIGN;
        end else if (dup) begin
          run_r    <= 1'b0;
          done_r   <= 1'b1;
          status_r <= sird_pkg::ST_DUP;
        end else if (at_end) begin
          run_r    <= 1'b0;
          done_r   <= 1'b1;
          status_r <= sird_pkg::ST_OK;
        end else begin
          done_r <= 1'b0;
          idx_r  <= idx_r + sird_pkg::DIG_W'(1);
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign res.done   = done_r;
  assign res.status = status_r;

endmodule

[hdl/sird_bitdiv.sv]
`timescale 1ns / 1ps

module sird_bitdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [sird_pkg::VAL_W-1:0]    dividend,
  input  logic [sird_pkg::LEN_W-1:0]    divisor,
  output sird_pkg::div_res_t            res
);

  logic                              run_r;
  logic                              done_r;
  logic [sird_pkg::BIT_CNT_W-1:0]    cnt_r;
  logic [sird_pkg::VAL_W-1:0]        quo_r;
  logic [sird_pkg::DIG_W-1:0]        rem_r;

  logic [sird_pkg::LEN_W-1:0]        trial;
  logic                              fits;
  logic [sird_pkg::LEN_W-1:0]        rem_nxt;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial   = {rem_r, quo_r[sird_pkg::VAL_W-1]};
    fits    = (trial >= divisor);
    rem_nxt = fits ? (trial - divisor) : trial;
  end

  // Control: one quotient bit per cycle, a done pulse after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (go) begin
        run_r  <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + sird_pkg::BIT_CNT_W'(1);
        if (cnt_r == sird_pkg::BIT_CNT_W'(sird_pkg::VAL_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= {quo_r[sird_pkg::VAL_W-2:0], fits};
      rem_r <= rem_nxt[sird_pkg::DIG_W-1:0];
    end
  end

  assign res.done  = done_r;
  assign res.quot  = quo_r;
  assign res.digit = rem_r;

endmodule

[hdl/signed_integer_to_radix_digits.sv]
`timescale 1ns / 1ps

// Converts a signed 32-bit value to text in the radix given by the length of the
// configured alphabet, one character per output strobe: '-' first for negative
// values, then the digits, most significant first, with out_last on the final one.
// A bad alphabet gives a single strobe with symbol 0, the error status and out_last.
// One item at a time: busy is high from acceptance until the final character is
// shown. The alphabet is scanned one symbol at a time; each digit then comes from the
// bit-serial divider, and the characters follow back to back. The receiver cannot
// stall: each strobe lasts exactly one cycle.
module signed_integer_to_radix_digits (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sird_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sird_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sird_pkg::VAL_W-1:0]   in_value,
  output logic                                out_valid,
  output logic [sird_pkg::SYM_W-1:0]          out_symbol,
  output logic [sird_pkg::STAT_W-1:0]         out_status,
  output logic                                out_last
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [sird_pkg::LEN_W-1:0]        radix_len_r;
  logic [sird_pkg::CFG_W-1:0]        alpha_lo_r;
  logic [sird_pkg::CFG_W-1:0]        alpha_hi_r;
  logic                              neg_r, neg_nxt;
  logic [sird_pkg::VAL_W-1:0]        mag_r, mag_nxt;
  logic [sird_pkg::ND_W-1:0]         nd_r, nd_nxt;
  logic [sird_pkg::DIG_W-1:0]        stk_r [sird_pkg::DIG_MAX];
  logic                              out_valid_r, out_valid_nxt;
  logic [sird_pkg::SYM_W-1:0]        out_symbol_r, out_symbol_nxt;
  logic [sird_pkg::STAT_W-1:0]       out_status_r, out_status_nxt;
  logic                              out_last_r, out_last_nxt;

  logic [sird_pkg::ALPHA_W-1:0]      alpha;
  logic [sird_pkg::LEN_W-1:0]        eff_len;
  logic [sird_pkg::VAL_W-1:0]        val_u;
  logic                              chk_go;
  logic                              div_go;
  logic [sird_pkg::VAL_W-1:0]        div_dividend;
  logic                              push;
  logic                              pop;
  sird_pkg::chk_res_t                chk_res;
  sird_pkg::div_res_t                div_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_len_r <= '0;
      alpha_lo_r  <= '0;
      alpha_hi_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sird_pkg::REG_RADIX:    radix_len_r <= cfg_data[sird_pkg::LEN_W-1:0];
        sird_pkg::REG_ALPHA_LO: alpha_lo_r  <= cfg_data;
        sird_pkg::REG_ALPHA_HI: alpha_hi_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The radix saturates at the cap.
  assign alpha   = {alpha_hi_r, alpha_lo_r};
  assign eff_len = (radix_len_r > sird_pkg::LEN_W'(sird_pkg::LEN_CAP)) ?
                   sird_pkg::LEN_W'(sird_pkg::LEN_CAP) : radix_len_r;
  assign val_u   = in_value;
  assign chk_go  = start && (state_r == S_IDLE);

  sird_alpha_chk u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (chk_go),
    .len   (eff_len),
    .alpha (alpha),
    .res   (chk_res)
  );

  sird_bitdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (eff_len),
    .res      (div_res)
  );

  // Sequencer: scan the alphabet (error item if bad), divide to a zero quotient, emit.
  always_comb begin
    state_nxt      = state_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    nd_nxt         = nd_r;
    div_go         = 1'b0;
    div_dividend   = mag_r;
    push           = 1'b0;
    pop            = 1'b0;
    out_valid_nxt  = 1'b0;
    out_symbol_nxt = '0;
    out_status_nxt = sird_pkg::ST_OK;
    out_last_nxt   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_nxt   = val_u[sird_pkg::VAL_W-1];
          mag_nxt   = val_u[sird_pkg::VAL_W-1] ? ('0 - val_u) : val_u;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (chk_res.done) begin
          if (chk_res.status != sird_pkg::ST_OK) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = chk_res.status;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            div_go    = 1'b1;
            nd_nxt    = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        div_dividend = div_res.quot;
        if (div_res.done) begin
          push   = 1'b1;
          nd_nxt = nd_r + sird_pkg::ND_W'(1);
          if (div_res.quot == '0) begin
            state_nxt = S_EMIT;
          end else begin
            div_go = 1'b1;
          end
        end
      end
      S_EMIT: begin
        out_valid_nxt = 1'b1;
        if (neg_r) begin
          out_symbol_nxt = sird_pkg::CH_MINUS;
          neg_nxt        = 1'b0;
        end else begin
          out_symbol_nxt = sird_pkg::sym_at(alpha, stk_r[0]);
          out_last_nxt   = (nd_r == sird_pkg::ND_W'(1));
          pop            = 1'b1;
          nd_nxt         = nd_r - sird_pkg::ND_W'(1);
          if (nd_r == sird_pkg::ND_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      neg_r       <= 1'b0;
      nd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      neg_r       <= neg_nxt;
      nd_r        <= nd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mag_r        <= mag_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Digit stack: digits arrive least significant first and leave most significant first.
  always_ff @(posedge clk) begin
    if (push) begin
      stk_r[0] <= div_res.digit;
      for (int k = 1; k < sird_pkg::DIG_MAX; k++) begin
        stk_r[k] <= stk_r[k-1];
      end
    end else if (pop) begin
      for (int k = 0; k < sird_pkg::DIG_MAX - 1; k++) begin
        stk_r[k] <= stk_r[k+1];
      end
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

[hdl/sird_props.sv]
`timescale 1ns / 1ps
`include "signed_integer_to_radix_digits_assert.svh"

module sird_props (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic [sird_pkg::SYM_W-1:0]         out_symbol,
  input logic [sird_pkg::STAT_W-1:0]        out_status,
  input logic                               out_last
);

  // Reset leaves the block idle and silent.
  `SIRD_ASSERT_RST(a_reset_idle, !rst_n |=> !busy && !out_valid, "not idle after reset")

  // An accepted item keeps the block busy in the next cycle.
  `SIRD_ASSERT(a_start_busy, start && !busy |=> busy, "accepted item did not set busy")

  // The final character of a run frees the block; earlier ones do not.
  `SIRD_ASSERT(a_last_free, out_valid && out_last |-> !busy, "busy after final character")
  `SIRD_ASSERT(a_mid_busy, out_valid && !out_last |-> busy, "idle in the middle of a run")

  // An error item stands alone, with a zero symbol.
  `SIRD_ASSERT(a_err_shape,
    out_valid && out_status != sird_pkg::ST_OK |-> out_symbol == '0 && out_last,
    "malformed error item")

endmodule

bind signed_integer_to_radix_digits sird_props u_sird_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_symbol (out_symbol),
  .out_status (out_status),
  .out_last   (out_last)
);
